### hw/rtl/sdff_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the signed decimal field formatter.
// No dependencies.
package sdff_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;

  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;

  localparam digit_t DIGIT_MAX = 4'd9;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

endpackage

### hw/rtl/sdff_digit_cell.sv
`timescale 1ns / 1ps
// One BCD digit cell of the conversion chain: clear, hold, add-3 and shift, or digit shift.
// Depends on sdff_pkg.
module sdff_digit_cell
  import sdff_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     bit_in,
  input  digit_t   dig_in,
  output digit_t   dig_q,
  output logic     carry_out
);

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign carry_out = adj[3];
  assign dig_q     = digit_r;

  always_comb begin
    case (op)
      CELL_CLEAR:  digit_nxt = '0;
      CELL_DABBLE: digit_nxt = {adj[2:0], bit_in};
      CELL_SHIFT:  digit_nxt = dig_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### hw/rtl/signed_decimal_field_formatter_unit.sv
`timescale 1ns / 1ps
// Signed decimal field formatter: one signed value in, its padded ASCII field out.
// After accept the 64 magnitude bits are dabbled through the 20-cell digit chain,
// leading zeros are shifted out, then pad and count are loaded and the field sent.
// Throughput: one character per cycle while out_stall is low; in_stall stays
// high until the field is out. rst_n is synchronous, active low, clears control only.
// Depends on sdff_pkg and sdff_digit_cell.
module signed_decimal_field_formatter_unit
  import sdff_pkg::*;
#(
  parameter int FIELD_CAP = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_narrow,
  input  logic                      in_left_align,
  input  logic                      in_zero_pad,
  input  logic                      in_plus_sign,
  input  logic                      in_space_sign,
  input  logic [6:0]                in_fld_width,
  input  logic                      in_zero_precision,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_ch,
  output logic                      out_last
);

  localparam logic [6:0] MaxW   = 7'(FIELD_CAP);
  localparam logic [4:0] NDigs  = 5'(NUM_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [5:0]         bit_cnt_r, bit_cnt_nxt;
  logic [4:0]         dig_r, dig_nxt;
  logic [6:0]         pad_r, pad_nxt;
  logic [6:0]         rem_r, rem_nxt;
  logic [6:0]         mw_r, mw_nxt;
  char_t              sign_r, sign_nxt;
  logic               has_sign_r, has_sign_nxt;
  logic               zero_r, zero_nxt;
  logic               zprec_r, zprec_nxt;
  logic               left_r, left_nxt;
  logic               zpad_r, zpad_nxt;
  logic               out_valid_r, out_valid_nxt;
  char_t              out_ch_r, out_ch_nxt;
  logic               out_last_r, out_last_nxt;

  cell_op_t           cell_op;
  digit_t             digit_w [NUM_DIGITS];
  logic               carry_w [NUM_DIGITS];

  logic               accept;
  logic               step;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag_in;
  logic               neg;
  logic [4:0]         nd;
  logic [6:0]         size;
  logic [6:0]         width;
  digit_t             top_dig;

  assign accept  = in_valid && !in_stall;
  assign step    = !out_valid_r || !out_stall;
  assign top_dig = digit_w[NUM_DIGITS-1];

  assign raw    = in_narrow ? {{32{in_value[31]}}, in_value[31:0]} : in_value;
  assign neg    = raw[VALUE_W-1];
  assign mag_in = neg ? (~raw + 64'd1) : raw;

  assign nd    = (zero_r && zprec_r) ? 5'd0 : dig_r;
  assign size  = 7'(nd) + 7'(has_sign_r);
  assign width = (mw_r > size) ? mw_r : size;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic   bit_in;
    digit_t dig_in;
    if (i == 0) begin : g_first
      assign bit_in = mag_r[VALUE_W-1];
      assign dig_in = '0;
    end else begin : g_rest
      assign bit_in = carry_w[i-1];
      assign dig_in = digit_w[i-1];
    end
    sdff_digit_cell u_cell (
      .clk       (clk),
      .op        (cell_op),
      .bit_in    (bit_in),
      .dig_in    (dig_in),
      .dig_q     (digit_w[i]),
      .carry_out (carry_w[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_nxt       = dig_r;
    pad_nxt       = pad_r;
    rem_nxt       = rem_r;
    mw_nxt        = mw_r;
    sign_nxt      = sign_r;
    has_sign_nxt  = has_sign_r;
    zero_nxt      = zero_r;
    zprec_nxt     = zprec_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;
    cell_op       = CELL_HOLD;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cell_op      = CELL_CLEAR;
          mag_nxt      = mag_in;
          zero_nxt     = (mag_in == '0);
          zprec_nxt    = in_zero_precision;
          left_nxt     = in_left_align;
          zpad_nxt     = in_zero_pad;
          mw_nxt       = (in_fld_width > MaxW) ? MaxW : in_fld_width;
          bit_cnt_nxt  = '1;
          dig_nxt      = NDigs;
          has_sign_nxt = neg || ((mag_in != '0) && (in_plus_sign || in_space_sign));
          sign_nxt     = neg ? CH_MINUS : (in_plus_sign ? CH_PLUS : CH_SPACE);
          state_nxt    = S_CONV;
        end
      end
      S_CONV: begin
        cell_op     = CELL_DABBLE;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 6'd1;
        if (bit_cnt_r == '0) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (top_dig == '0 && dig_r > 5'd1) begin
          cell_op = CELL_SHIFT;
          dig_nxt = dig_r - 5'd1;
        end else begin
          dig_nxt   = nd;
          pad_nxt   = width - size;
          rem_nxt   = width;
          state_nxt = (width == '0) ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (step) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rem_r == 7'd1);
          rem_nxt       = rem_r - 7'd1;
          if (rem_r == 7'd1) begin
            state_nxt = S_IDLE;
          end
          if (left_r) begin
            if (has_sign_r) begin
              out_ch_nxt   = sign_r;
              has_sign_nxt = 1'b0;
            end else if (dig_r != '0) begin
              out_ch_nxt = CH_ZERO | 8'(top_dig);
              dig_nxt    = dig_r - 5'd1;
              cell_op    = CELL_SHIFT;
            end else begin
              out_ch_nxt = CH_SPACE;
              pad_nxt    = pad_r - 7'd1;
            end
          end else if (zpad_r) begin
            if (has_sign_r) begin
              out_ch_nxt   = sign_r;
              has_sign_nxt = 1'b0;
            end else if (pad_r != '0) begin
              out_ch_nxt = CH_ZERO;
              pad_nxt    = pad_r - 7'd1;
            end else begin
              out_ch_nxt = CH_ZERO | 8'(top_dig);
              dig_nxt    = dig_r - 5'd1;
              cell_op    = CELL_SHIFT;
            end
          end else begin
            if (pad_r != '0) begin
              out_ch_nxt = CH_SPACE;
              pad_nxt    = pad_r - 7'd1;
            end else if (has_sign_r) begin
              out_ch_nxt   = sign_r;
              has_sign_nxt = 1'b0;
            end else begin
              out_ch_nxt = CH_ZERO | 8'(top_dig);
              dig_nxt    = dig_r - 5'd1;
              cell_op    = CELL_SHIFT;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_r      <= dig_nxt;
    pad_r      <= pad_nxt;
    rem_r      <= rem_nxt;
    mw_r       <= mw_nxt;
    sign_r     <= sign_nxt;
    has_sign_r <= has_sign_nxt;
    zero_r     <= zero_nxt;
    zprec_r    <= zprec_nxt;
    left_r     <= left_nxt;
    zpad_r     <= zpad_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (rem_r != '0))
    else $error("emit with no characters left");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (rem_r == pad_r + 7'(dig_r) + 7'(has_sign_r)))
    else $error("remaining count out of step with pad, digits and sign");

  a_last_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && step && rem_r == 7'd1) |=>
      (out_valid_r && out_last_r && state_r != S_EMIT))
    else $error("still emitting after last word");

  a_top_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM || state_r == S_EMIT) |-> (top_dig <= DIGIT_MAX))
    else $error("digit chain holds a non-decimal digit");
`endif

endmodule

### verif/signed_decimal_field_formatter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for signed_decimal_field_formatter_unit: directed table plus random fields,
// every output word compared to typed text or format_field. Depends on sdff_pkg and the unit RTL.
module signed_decimal_field_formatter_unit_tb;
  import sdff_pkg::*;

  localparam int FIELD_MAX  = 64;
  localparam int NDIR       = 25;
  localparam int NRAND      = 405;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 600;
  localparam int QUIET_FROM = 250;
  localparam int QUIET_TO   = 330;
  localparam int DRAIN_AT   = 200;
  localparam int SETTLE     = 200;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [63:0] value;
    logic        narrow;
    logic        left_align;
    logic        zero_pad;
    logic        plus_sign;
    logic        space_sign;
    logic [6:0]  fld_width;
    logic        zero_precision;
  } in_word_t;

  typedef struct packed {
    in_word_t word;
    logic     typed;
  } dir_row_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } field_char_t;

  typedef char_t char_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_value = '0;
  logic        in_narrow = 1'b0;
  logic        in_left_align = 1'b0;
  logic        in_zero_pad = 1'b0;
  logic        in_plus_sign = 1'b0;
  logic        in_space_sign = 1'b0;
  logic [6:0]  in_fld_width = '0;
  logic        in_zero_precision = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_ch;
  logic        out_last;

  field_char_t expected_chars[$];
  bit          typed_flags[$];
  string       typed_texts[$];
  int          in_count = 0;
  int          chars_checked = 0;
  int          fail_count = 0;
  int          hold_cycles = 0;
  bit          hold_done = 1'b0;
  logic        quiet;

  dir_row_t dir_rows [NDIR];
  string    dir_text [NDIR];

  assign quiet = (in_count >= QUIET_FROM) && (in_count < QUIET_TO);

  always #5 clk = ~clk;

  signed_decimal_field_formatter_unit #(
    .FIELD_CAP(FIELD_MAX)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_narrow        (in_narrow),
    .in_left_align    (in_left_align),
    .in_zero_pad      (in_zero_pad),
    .in_plus_sign     (in_plus_sign),
    .in_space_sign    (in_space_sign),
    .in_fld_width     (in_fld_width),
    .in_zero_precision(in_zero_precision),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ch           (out_ch),
    .out_last         (out_last)
  );

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic char_q_t format_field(in_word_t w);
    char_q_t     text;
    char_t       digs[20];
    logic [63:0] raw;
    logic [63:0] mag;
    char_t       sign_ch;
    bit          has_sign;
    int          ndig;
    int          size;
    int          mw;
    int          pad;
    raw = w.value;
    if (w.narrow) begin
      raw = {{32{raw[31]}}, raw[31:0]};
    end
    mag = raw[63] ? (~raw + 64'd1) : raw;
    has_sign = 1'b1;
    if (raw[63]) begin
      sign_ch = CH_MINUS;
    end else if (mag != 0 && w.plus_sign) begin
      sign_ch = CH_PLUS;
    end else if (mag != 0 && w.space_sign) begin
      sign_ch = CH_SPACE;
    end else begin
      has_sign = 1'b0;
      sign_ch = CH_SPACE;
    end
    ndig = 0;
    if (mag != 0 || !w.zero_precision) begin
      do begin
        digs[ndig] = CH_ZERO + char_t'(mag % 64'd10);
        mag = mag / 64'd10;
        ndig++;
      end while (mag != 0);
    end
    size = ndig + int'(has_sign);
    mw = (w.fld_width > FIELD_MAX) ? FIELD_MAX : int'(w.fld_width);
    pad = (mw > size) ? mw - size : 0;
    if (w.left_align) begin
      if (has_sign) text.push_back(sign_ch);
      for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
      repeat (pad) text.push_back(CH_SPACE);
    end else if (w.zero_pad) begin
      if (has_sign) text.push_back(sign_ch);
      repeat (pad) text.push_back(CH_ZERO);
      for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
    end else begin
      repeat (pad) text.push_back(CH_SPACE);
      if (has_sign) text.push_back(sign_ch);
      for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
    end
    return text;
  endfunction

  // input accept -> expectations; output accept -> compare
  always @(posedge clk) begin
    in_word_t    w;
    char_q_t     text;
    field_char_t exp_c;
    bit          typed;
    string       typed_s;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_count <= in_count + 1;
        w = '{in_value, in_narrow, in_left_align, in_zero_pad, in_plus_sign,
              in_space_sign, in_fld_width, in_zero_precision};
        typed = typed_flags.pop_front();
        typed_s = typed_texts.pop_front();
        text.delete();
        if (typed) begin
          for (int i = 0; i < typed_s.len(); i++) text.push_back(char_t'(typed_s[i]));
        end else begin
          text = format_field(w);
        end
        for (int i = 0; i < text.size(); i++) begin
          exp_c.ch = text[i];
          exp_c.last = (i == text.size() - 1);
          expected_chars.push_back(exp_c);
        end
      end
      if (out_valid && !out_stall) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected word ch=8'h%02h last=%0b", out_ch, out_last));
        end else begin
          exp_c = expected_chars.pop_front();
          if (out_ch !== exp_c.ch) begin
            report_mismatch($sformatf("word %0d ch: got 8'h%02h, want 8'h%02h",
                                      chars_checked, out_ch, exp_c.ch));
          end
          if (out_last !== exp_c.last) begin
            report_mismatch($sformatf("word %0d last: got %0b, want %0b",
                                      chars_checked, out_last, exp_c.last));
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, a quiet stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (in_count == HOLD_AT && !hold_done) begin
      out_stall <= 1'b1;
      hold_cycles <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  task automatic send_field(in_word_t w, bit typed, string text);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_flags.push_back(typed);
    typed_texts.push_back(text);
    in_valid <= 1'b1;
    in_value <= w.value;
    in_narrow <= w.narrow;
    in_left_align <= w.left_align;
    in_zero_pad <= w.zero_pad;
    in_plus_sign <= w.plus_sign;
    in_space_sign <= w.space_sign;
    in_fld_width <= w.fld_width;
    in_zero_precision <= w.zero_precision;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    in_word_t    w;
    logic [63:0] p;
    int          k;
    // value, narrow, left, zero_pad, plus, space, fld_width, zero_precision; typed
    dir_rows = '{
      '{'{64'd0,                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{-64'sd1,                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'd0,                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b1}, 1'b1},
      '{'{64'd0,                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd3,   1'b1}, 1'b1},
      '{'{64'd0,                  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd3,   1'b1}, 1'b1},
      '{'{64'd0,                  1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 7'd0,   1'b0}, 1'b1},
      '{'{64'd42,                 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd5,   1'b0}, 1'b1},
      '{'{64'd42,                 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0}, 1'b1},
      '{'{64'd42,                 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 7'd0,   1'b0}, 1'b1},
      '{'{-64'sd42,               1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 7'd6,   1'b0}, 1'b1},
      '{'{-64'sd42,               1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd6,   1'b0}, 1'b1},
      '{'{64'd7,                  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd4,   1'b0}, 1'b1},
      '{'{64'd12345,              1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd2,   1'b0}, 1'b1},
      '{'{64'h0000_0000_8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'hFFFF_FFFF_7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'h1234_5678_0000_0005, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b1}, 1'b1},
      '{'{64'd10,                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0}, 1'b1},
      '{'{64'd1,                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd127, 1'b0}, 1'b0},
      '{'{64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 7'd64,  1'b0}, 1'b0},
      '{'{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 7'd64,  1'b1}, 1'b0},
      '{'{-64'sd1,                1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 7'd65,  1'b0}, 1'b0},
      '{'{64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 7'h55,  1'b0}, 1'b0}
    };
    dir_text = '{"0", "9223372036854775807", "-9223372036854775808", "-1", "", "   ",
                 "000", "0", "  +42", " 42", "+42", "-42   ", "-00042", "7   ", "12345",
                 "-2147483648", "2147483647", "5", "", "10", "", "", "", "", ""};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NDIR; r++) begin
      send_field(dir_rows[r].word, dir_rows[r].typed, dir_text[r]);
    end

    for (int n = 0; n < NRAND; n++) begin
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_chars.size() != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: w.value = {$urandom, $urandom};
        3, 4: begin
          w.value = 64'($urandom_range(0, 999));
          if ($urandom_range(1)) w.value = -w.value;
        end
        5, 6: begin
          p = 64'd1;
          k = $urandom_range(0, 18);
          repeat (k) p = p * 64'd10;
          if ($urandom_range(1)) p = p - 64'd1;
          if ($urandom_range(1)) p = -p;
          w.value = p;
        end
        7: w.value = 64'd0;
        8: begin
          case ($urandom_range(0, 4))
            0: w.value = 64'h8000_0000_0000_0000;
            1: w.value = 64'h7FFF_FFFF_FFFF_FFFF;
            2: w.value = {$urandom, 32'h8000_0000};
            3: w.value = {$urandom, 32'h7FFF_FFFF};
            default: w.value = '1;
          endcase
        end
        default: w.value = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
      endcase
      w.narrow = 1'($urandom_range(1));
      w.left_align = 1'($urandom_range(1));
      w.zero_pad = 1'($urandom_range(1));
      w.plus_sign = 1'($urandom_range(1));
      w.space_sign = 1'($urandom_range(1));
      w.zero_precision = ($urandom_range(99) < 30);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w.fld_width = 7'($urandom_range(0, 22));
        6, 7, 8:          w.fld_width = 7'($urandom_range(0, 64));
        default:          w.fld_width = 7'($urandom_range(0, 127));
      endcase
      send_field(w, 1'b0, "");
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d fields (%0d table rows, %0d random) and %0d output words.",
             NDIR + NRAND, NDIR, NRAND, chars_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
hw/rtl/sdff_pkg.sv
hw/rtl/sdff_digit_cell.sv
hw/rtl/signed_decimal_field_formatter_unit.sv
verif/signed_decimal_field_formatter_unit_tb.sv
